/* src/pgl_pkg.sv */
// shared types and constants for the pseudocolor gradient table
`timescale 1ns / 1ps
package pgl_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_SEG   = 2'd1;
  localparam logic [1:0] MODE_MAP   = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEG,
    S_DIV,
    S_READ,
    S_WAIT,
    S_OUT
  } state_e;

endpackage

/* src/pgl_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
module pgl_ram #(
  parameter int Width = 24,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

/* src/pgl_divider.sv */
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pgl_divider #(
  parameter int Bits = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [Bits-1:0] num_i,
  input  logic [Bits-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [Bits-1:0] quot_o,
  output logic [Bits-1:0] rem_o
);

  localparam int CntW = $clog2(Bits + 1);

  logic [Bits-1:0] rem_q, rem_d, quot_q, quot_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [Bits:0]   trial;

  assign trial  = {rem_q, quot_q[Bits-1]} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_d;
  assign rem_o  = rem_d;
  assign busy_o = busy_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quot_d = num_i;
      den_d  = den_i;
      cnt_d  = CntW'(Bits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Bits]) begin
        rem_d = trial[Bits-1:0];
      end else begin
        rem_d = {rem_q[Bits-2:0], quot_q[Bits-1]};
      end
      quot_d = {quot_q[Bits-2:0], ~trial[Bits]};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

endmodule

/* src/pseudocolor_gradient_lut.sv */
// top level: colour table with gradient fill and sample mapping
// Usage: one input word per item on in_valid_i/in_ready_o, one result word per item on
// out_valid_o/out_ready_i. The user must write bounds on cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the block leaves it unenforced. A clear word, an unused mode, a reversed
// segment or a map on an empty table goes straight from idle to posting its result. A
// segment word runs the shared serial divider once per channel for each stored entry, with
// W = max(SAMPLE_BITS,16)+2+clog2(TABLE_DEPTH+1) divider bits (28 by default), then writes
// the table; a one-entry segment takes colour a without a divide, and entries past a full
// table are dropped. A map word runs one divide, then a ram read (S_READ), takes the read
// data (S_WAIT) and posts the result (S_OUT); the divide is skipped when the bounds are
// equal. One item is in flight at a time. The result sits in its own output register, so
// the next word is accepted while it waits; a finished item holds in its last state until
// that register is free. Reset empties the table (fill count zero) and sets bounds to 0 and
// 255; ram contents are left as they are, only entries below the fill count are ever read.
// A stalled receiver holds the result; the block stalls once its next result is ready.
`timescale 1ns / 1ps
module pseudocolor_gradient_lut
  import pgl_pkg::*;
#(
  parameter int TABLE_DEPTH = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [7:0]             seg_start_i,
  input  logic [7:0]             seg_end_i,
  input  logic [7:0]             color_a_red_i,
  input  logic [7:0]             color_a_green_i,
  input  logic [7:0]             color_a_blue_i,
  input  logic [7:0]             color_b_red_i,
  input  logic [7:0]             color_b_green_i,
  input  logic [7:0]             color_b_blue_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  output logic [1:0]             status_o,
  output logic [9:0]             entry_count_o
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int ZW   = (SAMPLE_BITS > 16 ? SAMPLE_BITS : 16) + 2;
  localparam int DW   = ZW + CW;

  state_e state_q, state_d;

  logic signed [15:0] low_q, high_q;
  logic [CW-1:0]      fill_q, fill_d;
  logic [1:0]         mode_q;
  logic [7:0]         cnt_q, cnt_d, nm1_q;
  logic [1:0]         ch_q, ch_d;
  logic [7:0]         ca_q [3], cb_q [3];
  logic [7:0]         res_q [3], res_d [3];
  logic               sneg_q;
  logic [1:0]         stat_q, stat_d;
  logic               outv_q, outv_d;
  logic signed [ZW-1:0] z_q;
  logic [AW-1:0]      idx_q, idx_d;

  // output register, free of the working registers
  logic [7:0]         ocol_q [3];
  logic [1:0]         ostat_q;
  logic [9:0]         ocnt_q;
  logic               out_load;

  // divider
  logic           div_start, div_done, div_busy;
  logic [DW-1:0]  div_num, div_den, div_quot, div_rem;

  pgl_divider #(.Bits(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_rdata;

  pgl_ram #(.Width(24), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i({res_q[0], res_q[1], res_q[2]}),
    .rdata_o(ram_rdata)
  );

  // operand setup
  logic signed [ZW-1:0] samp_x, lo_x, hi_x, zc, span, zoff;
  logic signed [9:0]    cdiff;
  logic [17:0]          cprod;
  logic [DW-1:0]        map_prod;
  logic [CW-1:0]        last;

  assign samp_x = ZW'(sample_i);
  assign lo_x   = ZW'(low_q);
  assign hi_x   = ZW'(high_q);
  assign last   = fill_q - CW'(1);
  assign span   = hi_x - lo_x;
  assign zoff   = z_q - lo_x;
  // last*(z-low) fits: |zoff| < 2^17 so product < 2^(ZW-1+CW)
  assign map_prod = DW'(last) * DW'(zoff[ZW-1] ? -zoff : zoff);
  assign cdiff  = {2'b00, cb_q[ch_q]} - {2'b00, ca_q[ch_q]};
  assign cprod  = 18'(cdiff[9] ? -cdiff : cdiff) * 18'(cnt_q);

  always_comb begin
    zc = samp_x;
    if (samp_x > hi_x) begin
      zc = hi_x;
    end else if (samp_x < lo_x) begin
      zc = lo_x;
    end
  end

  // floor of signed quotient from magnitude quotient
  logic [DW-1:0]        qmag;
  logic                 qneg, rem_nz;
  logic signed [DW:0]   qsig;
  logic [DW-1:0]        magn, magd;

  assign qneg = (state_q == S_SEG) ? sneg_q : (zoff[ZW-1] ^ span[ZW-1]);
  assign magn = (state_q == S_SEG) ? DW'(cprod) : map_prod;
  assign magd = (state_q == S_SEG) ? DW'(nm1_q)
                                   : DW'(span[ZW-1] ? -span : span);
  assign qmag = div_quot;
  assign rem_nz = (div_rem != '0);
  assign qsig = qneg ? -$signed({1'b0, qmag}) - $signed({{DW{1'b0}}, rem_nz})
                     : $signed({1'b0, qmag});

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    res_d     = res_q;
    stat_d    = stat_q;
    outv_d    = outv_q;
    idx_d     = idx_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_num   = magn;
    div_den   = magd;
    ram_we    = 1'b0;
    ram_addr  = (state_q == S_READ) ? idx_q : fill_q[AW-1:0];
    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          res_d  = '{8'd0, 8'd0, 8'd0};
          stat_d = ST_OK;
          cnt_d  = '0;
          ch_d   = '0;
          if (mode_i == MODE_CLEAR) begin
            fill_d = '0;
            state_d = S_OUT;
          end else if (mode_i == MODE_SEG && seg_end_i >= seg_start_i) begin
            state_d = S_SEG;
          end else if (mode_i == MODE_MAP) begin
            if (fill_q == '0) begin
              stat_d  = ST_EMPTY;
              state_d = S_OUT;
            end else begin
              state_d = S_DIV;
            end
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SEG: begin
        // per channel: start divide, wait, then store; write when all three are done
        if (fill_q == CW'(TABLE_DEPTH)) begin
          stat_d = ST_FULL;
          ch_d   = 2'd0;
          if (cnt_q == nm1_q) begin
            state_d = S_OUT;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end else if (ch_q == 2'd3) begin
          ram_we = 1'b1;
          fill_d = fill_q + CW'(1);
          ch_d   = 2'd0;
          if (cnt_q == nm1_q) begin
            state_d = S_OUT;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end else if (nm1_q == 8'd0) begin
          res_d[ch_q] = ca_q[ch_q];
          ch_d = ch_q + 2'd1;
        end else if (!div_done && !div_busy) begin
          div_start = 1'b1;
        end else if (div_done) begin
          res_d[ch_q] = ca_q[ch_q] + qsig[7:0];
          ch_d = ch_q + 2'd1;
        end
      end
      S_DIV: begin
        if (span == '0) begin
          idx_d   = '0;
          state_d = S_READ;
        end else if (!div_done && !div_busy) begin
          div_start = 1'b1;
        end else if (div_done) begin
          if (qsig[DW]) begin
            idx_d = '0;
          end else if (qsig > $signed({1'b0, DW'(last)})) begin
            idx_d = last[AW-1:0];
          end else begin
            idx_d = qsig[AW-1:0];
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        res_d   = '{ram_rdata[23:16], ram_rdata[15:8], ram_rdata[7:0]};
        state_d = S_OUT;
      end
      S_OUT: begin
        // wait here until the output register is free
        if (!outv_q || out_ready_i) begin
          outv_d   = 1'b1;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      outv_q  <= 1'b0;
      low_q   <= 16'sd0;
      high_q  <= 16'sd255;
      cnt_q   <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      outv_q  <= outv_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LOW) begin
          low_q <= cfg_data_i;
        end else begin
          high_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    stat_q <= stat_d;
    idx_q  <= idx_d;
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      nm1_q  <= seg_end_i - seg_start_i;
      ca_q   <= '{color_a_red_i, color_a_green_i, color_a_blue_i};
      cb_q   <= '{color_b_red_i, color_b_green_i, color_b_blue_i};
      z_q    <= zc;
    end
    if (state_q == S_SEG) begin
      sneg_q <= cdiff[9];
    end
    if (out_load) begin
      // only a map word answers a colour
      if (mode_q == MODE_MAP) begin
        ocol_q <= res_q;
      end else begin
        ocol_q <= '{8'd0, 8'd0, 8'd0};
      end
      ostat_q <= stat_q;
      ocnt_q  <= 10'(fill_q);
    end
  end

  assign out_valid_o   = outv_q;
  assign red_o         = ocol_q[0];
  assign green_o       = ocol_q[1];
  assign blue_o        = ocol_q[2];
  assign status_o      = ostat_q;
  assign entry_count_o = ocnt_q;

endmodule

/* src/pgl_checker.sv */
// port-level checks for the pseudocolor gradient table
`timescale 1ns / 1ps
module pgl_checker
  import pgl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [9:0] entry_count_o,
  input logic [7:0] red_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(entry_count_o) && $stable(red_o))
    else $error("result dropped under stall");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_FULL))
    else $error("unknown status code");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == 10'd0 && red_o == 8'd0)
    else $error("empty status with entries");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> red_o == 8'd0)
    else $error("segment word answered a colour");

endmodule

bind pseudocolor_gradient_lut pgl_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .entry_count_o, .red_o
);

/* test/tb.sv */
// self-checking testbench for the pseudocolor gradient table
`timescale 1ns / 1ps
module tb;
  import pgl_pkg::*;

  localparam int DEPTH = 512;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int PHASE_WORDS = 360;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample;
    logic [7:0]         seg_start;
    logic [7:0]         seg_end;
    logic [7:0]         a_red;
    logic [7:0]         a_green;
    logic [7:0]         a_blue;
    logic [7:0]         b_red;
    logic [7:0]         b_green;
    logic [7:0]         b_blue;
  } lut_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
    logic [9:0] count;
  } lut_color_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_LOW;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  lut_word_t   cur_word = '0;
  logic [7:0]  red_o, green_o, blue_o;
  logic [1:0]  status_o;
  logic [9:0]  entry_count_o;

  pseudocolor_gradient_lut uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (cur_word.mode),
    .sample_i       (cur_word.sample),
    .seg_start_i    (cur_word.seg_start),
    .seg_end_i      (cur_word.seg_end),
    .color_a_red_i  (cur_word.a_red),
    .color_a_green_i(cur_word.a_green),
    .color_a_blue_i (cur_word.a_blue),
    .color_b_red_i  (cur_word.b_red),
    .color_b_green_i(cur_word.b_green),
    .color_b_blue_i (cur_word.b_blue),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the table and bounds
  logic [7:0] shadow_red [DEPTH];
  logic [7:0] shadow_green [DEPTH];
  logic [7:0] shadow_blue [DEPTH];
  int         shadow_fill = 0;
  longint     bound_low = 0;
  longint     bound_high = 255;

  lut_word_t  pending_words[$];
  lut_color_t expected_colors[$];
  bit         word_taken = 1'b0;
  int         mismatches = 0;
  longint     cycles = 0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, longint i, longint n);
    longint av, bv;
    av = a;
    bv = b;
    if (n <= 1) return a;
    return 8'((av + floor_div((bv - av) * i, n - 1)) & 255);
  endfunction

  function automatic lut_color_t lookup_color(lut_word_t w);
    lut_color_t res;
    longint n, z, idx, last;
    res = '0;
    case (w.mode)
      MODE_CLEAR: shadow_fill = 0;
      MODE_SEG: begin
        if (w.seg_end >= w.seg_start) begin
          n = longint'(w.seg_end) - longint'(w.seg_start) + 1;
          for (longint i = 0; i < n; i++) begin
            if (shadow_fill < DEPTH) begin
              shadow_red[shadow_fill] = blend(w.a_red, w.b_red, i, n);
              shadow_green[shadow_fill] = blend(w.a_green, w.b_green, i, n);
              shadow_blue[shadow_fill] = blend(w.a_blue, w.b_blue, i, n);
              shadow_fill++;
            end else begin
              res.status = ST_FULL;
            end
          end
        end
      end
      MODE_MAP: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          z = $signed(w.sample);
          idx = 0;
          last = shadow_fill - 1;
          if (z > bound_high) z = bound_high;
          else if (z < bound_low) z = bound_low;
          if (bound_high != bound_low)
            idx = floor_div(last * (z - bound_low), bound_high - bound_low);
          if (idx < 0) idx = 0;
          if (idx > last) idx = last;
          res.red = shadow_red[idx];
          res.green = shadow_green[idx];
          res.blue = shadow_blue[idx];
        end
      end
      default: ;
    endcase
    res.count = 10'(shadow_fill);
    return res;
  endfunction

  function automatic bit quiet_window();
    return cycles > 30000 && cycles < 90000;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pseudocolor_gradient_lut test failed");
      $finish;
    end
  end

  // accepted words update the shadow state
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      word_taken = 1'b1;
      expected_colors = {expected_colors, lookup_color(cur_word)};
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      word_taken = 1'b0;
      if (pending_words.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 11)) begin
        cur_word <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= quiet_window() || $urandom_range(0, 99) >= 11;
  end

  always @(posedge clk_i) begin
    lut_color_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{red_o, green_o, blue_o, status_o, entry_count_o};
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic lut_word_t seg_word(int s, int e, logic [23:0] a, logic [23:0] b);
    lut_word_t w;
    w = '0;
    w.mode = MODE_SEG;
    w.seg_start = 8'(s);
    w.seg_end = 8'(e);
    {w.a_red, w.a_green, w.a_blue} = a;
    {w.b_red, w.b_green, w.b_blue} = b;
    w.sample = 16'($urandom);
    return w;
  endfunction

  function automatic lut_word_t map_word(longint z);
    lut_word_t w;
    w = lut_word_t'({$urandom, $urandom, $urandom});
    w.mode = MODE_MAP;
    w.sample = 16'(z);
    return w;
  endfunction

  function automatic lut_word_t random_word();
    lut_word_t w;
    int pick, s, len;
    longint z;
    pick = $urandom_range(0, 99);
    w = lut_word_t'({$urandom, $urandom, $urandom});
    if (pick < 6) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 48) begin
      s = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 2) len = $urandom_range(0, 255);
      else if ($urandom_range(0, 99) < 6) len = -int'($urandom_range(1, 20));
      else len = $urandom_range(0, 15);
      w = seg_word(s, (s + len > 255) ? 255 : (s + len < 0 ? 0 : s + len),
                   24'($urandom), 24'($urandom));
    end else if (pick < 96) begin
      if ($urandom_range(0, 1) == 0 || bound_high == bound_low) begin
        z = $signed(16'($urandom));
      end else if (bound_low < bound_high) begin
        z = bound_low + $urandom_range(0, 32'(bound_high - bound_low));
      end else begin
        z = bound_high + $urandom_range(0, 32'(bound_low - bound_high));
      end
      w = map_word(z);
    end else begin
      w.mode = MODE_NOP;
    end
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || expected_colors.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_bounds(logic [15:0] lo, logic [15:0] hi);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_LOW;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i <= REG_HIGH;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bound_low = $signed(lo);
    bound_high = $signed(hi);
  endtask

  task automatic queue_word(lut_word_t w);
    pending_words = {pending_words, w};
  endtask

  initial begin
    logic [15:0] lo_set [5];
    logic [15:0] hi_set [5];
    lo_set = '{16'h8000, 16'h7fff, 16'd100, 16'hff00, 16'h0000};
    hi_set = '{16'h7fff, 16'h8000, 16'd100, 16'h00ff, 16'h0000};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words at reset bounds
    queue_word(map_word(5));
    queue_word(seg_word(7, 7, 24'h123456, 24'hffffff));
    queue_word(map_word(-32768));
    queue_word(seg_word(9, 3, 24'hffffff, 24'h000000));
    queue_word(seg_word(0, 255, 24'h000000, 24'hffffff));
    queue_word(seg_word(0, 255, 24'hff00ff, 24'h00ff00));
    queue_word(map_word(0));
    queue_word(map_word(255));
    queue_word(map_word(128));
    queue_word(map_word(32767));
    queue_word(seg_word(3, 4, 24'h010203, 24'hfefdfc));
    queue_word(map_word(200));
    begin
      lut_word_t w;
      w = '1;
      w.mode = MODE_NOP;
      queue_word(w);
      w = '0;
      w.mode = MODE_CLEAR;
      queue_word(w);
    end
    queue_word(map_word(17));
    queue_word(seg_word(255, 255, 24'hffffff, 24'h000000));
    queue_word(seg_word(0, 1, 24'hff0000, 24'h00ffff));
    queue_word(map_word(-1));
    queue_word(map_word(300));
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p == 4) write_bounds(16'($urandom), 16'($urandom));
      else write_bounds(lo_set[p], hi_set[p]);
      for (int k = 0; k < PHASE_WORDS; k++) queue_word(random_word());
      drain();
    end

    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("pseudocolor_gradient_lut test passed");
    end else begin
      $display("pseudocolor_gradient_lut test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pgl_pkg.sv
src/pgl_ram.sv
src/pgl_divider.sv
src/pseudocolor_gradient_lut.sv
src/pgl_checker.sv
test/tb.sv
